[src/rde_pkg.sv]
// Package for the radix digit emitter: widths, limits, command and status structs,
// and the digit glyph function. No dependencies.
package rde_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned NUMBER_W    = 64;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned RADIX_MIN   = 2;
  localparam int unsigned RADIX_MAX   = 36;
  localparam int unsigned NUM_DECIMAL = 10;
  localparam int unsigned NUM_GLYPHS  = 36;

  // The divider retires this many quotient bits per cycle.
  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned CHUNKS    = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W     = CHUNKS * STEP_BITS;
  localparam int unsigned CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;

  typedef struct packed {
    logic start;     // capture a new item and clear the digit count
    logic step;      // one divider step
    logic fetch;     // read the digit store at the emit index
    logic show;      // load the output register with the fetched digit
    logic show_bad;  // load the output register with the invalid-radix result
  } rde_cmd_t;

  typedef struct packed {
    logic radix_bad;   // radix on the input channel is outside the valid range
    logic chunk_last;  // this divider cycle finishes one digit
    logic quot_nz;     // quotient of the finishing division is nonzero
    logic store_full;  // the finishing digit fills the digit store
    logic rd_last;     // the emit index points at the least significant digit, the last one emitted
  } rde_status_t;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_W'(NUM_DECIMAL)) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_W'(NUM_GLYPHS)) begin
      ch = CHAR_A + CHAR_W'(d) - CHAR_W'(NUM_DECIMAL);
    end else begin
      ch = '0;
    end
    return ch;
  endfunction

endpackage

[src/rde_if.sv]
// Valid/ready channel interfaces for the radix digit emitter input and output items.
// Depends on rde_pkg for the field widths.
interface rde_in_if;
  logic                         valid;
  logic                         ready;
  logic [rde_pkg::NUMBER_W-1:0] number;
  logic [rde_pkg::RADIX_W-1:0]  radix;

  modport source (output valid, output number, output radix, input ready);
  modport sink   (input valid, input number, input radix, output ready);
endinterface

interface rde_out_if;
  logic                       valid;
  logic                       ready;
  logic [rde_pkg::CHAR_W-1:0] digit_char;
  logic                       last_digit;
  logic                       bad_radix;

  modport source (output valid, output digit_char, output last_digit, output bad_radix,
                  input ready);
  modport sink   (input valid, input digit_char, input last_digit, input bad_radix,
                  output ready);
endinterface

[src/rde_datapath.sv]
// Datapath of the radix digit emitter: chunked restoring divider, digit store,
// emit index and output payload register. Depends on rde_pkg.
module rde_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rde_pkg::NUMBER_W-1:0] number_i,
  input  logic [rde_pkg::RADIX_W-1:0]  radix_i,
  input  rde_pkg::rde_cmd_t            cmd_i,
  output rde_pkg::rde_status_t         status_o,
  output logic [rde_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_digit_o,
  output logic                         bad_radix_o
);

  logic [rde_pkg::PAD_W-1:0]     work_q;
  logic [rde_pkg::RADIX_W-1:0]   radix_q;
  logic [rde_pkg::DIGIT_W-1:0]   rem_q;
  logic                          nz_q;
  logic [rde_pkg::CHUNK_W-1:0]   chunk_q;
  logic [rde_pkg::COUNT_W-1:0]   count_q;
  logic [rde_pkg::ADDR_W-1:0]    rd_idx_q;
  logic [rde_pkg::DIGIT_W-1:0]   rd_data_q;
  logic [rde_pkg::DIGIT_W-1:0]   store_q [rde_pkg::STORE_DEPTH];

  logic [rde_pkg::STEP_BITS-1:0] qbits;
  logic [rde_pkg::DIGIT_W-1:0]   rem_d;
  logic                          chunk_last;

  // Eight restoring steps on the top byte; the partial remainder stays below the radix.
  always_comb begin
    logic [rde_pkg::DIGIT_W:0]     r;
    logic [rde_pkg::STEP_BITS-1:0] top;
    top = work_q[rde_pkg::PAD_W-1 -: rde_pkg::STEP_BITS];
    r   = {1'b0, rem_q};
    for (int i = rde_pkg::STEP_BITS - 1; i >= 0; i--) begin
      r = {r[rde_pkg::DIGIT_W-1:0], top[i]};
      if (r >= {1'b0, radix_q}) begin
        r        = r - {1'b0, radix_q};
        qbits[i] = 1'b1;
      end else begin
        qbits[i] = 1'b0;
      end
    end
    rem_d = r[rde_pkg::DIGIT_W-1:0];
  end

  assign chunk_last = (chunk_q == rde_pkg::CHUNK_W'(rde_pkg::CHUNKS - 1));

  assign status_o.radix_bad  = (radix_i < rde_pkg::RADIX_W'(rde_pkg::RADIX_MIN)) ||
                               (radix_i > rde_pkg::RADIX_W'(rde_pkg::RADIX_MAX));
  assign status_o.chunk_last = chunk_last;
  assign status_o.quot_nz    = nz_q | (|qbits);
  assign status_o.store_full = (count_q == rde_pkg::COUNT_W'(rde_pkg::STORE_DEPTH - 1));
  assign status_o.rd_last    = (rd_idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q  <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      nz_q     <= 1'b0;
    end else if (cmd_i.start) begin
      chunk_q <= '0;
      count_q <= '0;
      nz_q    <= 1'b0;
    end else if (cmd_i.step) begin
      if (chunk_last) begin
        chunk_q  <= '0;
        nz_q     <= 1'b0;
        count_q  <= count_q + 1'b1;
        rd_idx_q <= count_q[rde_pkg::ADDR_W-1:0];
      end else begin
        chunk_q <= chunk_q + 1'b1;
        nz_q    <= nz_q | (|qbits);
      end
    end else if (cmd_i.show) begin
      rd_idx_q <= rd_idx_q - 1'b1;
    end
  end

  // Working dividend, which turns into the quotient one byte per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      work_q  <= rde_pkg::PAD_W'(number_i[rde_pkg::VALUE_WIDTH-1:0]);
      radix_q <= radix_i;
      rem_q   <= '0;
    end else if (cmd_i.step) begin
      work_q <= (work_q << rde_pkg::STEP_BITS) | rde_pkg::PAD_W'(qbits);
      rem_q  <= chunk_last ? '0 : rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && chunk_last) begin
      store_q[count_q[rde_pkg::ADDR_W-1:0]] <= rem_d;
    end
    if (cmd_i.fetch) begin
      rd_data_q <= store_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.show) begin
      digit_char_o <= rde_pkg::digit_glyph(rd_data_q);
      last_digit_o <= (rd_idx_q == '0);
      bad_radix_o  <= 1'b0;
    end else if (cmd_i.show_bad) begin
      digit_char_o <= '0;
      last_digit_o <= 1'b1;
      bad_radix_o  <= 1'b1;
    end
  end

endmodule

[src/rde_ctrl.sv]
// Controller of the radix digit emitter: sequences divide, fetch and show steps
// and owns the output valid flag. Depends on rde_pkg.
module rde_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rde_pkg::rde_status_t status_i,
  output rde_pkg::rde_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW,
    ST_BAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register is free if empty or being taken at this edge.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.radix_bad ? ST_BAD : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.chunk_last && !(status_i.quot_nz && !status_i.store_full)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_o.fetch = 1'b1;
          state_d     = ST_SHOW;
        end
      end
      ST_SHOW: begin
        cmd_o.show = 1'b1;
        state_d    = status_i.rd_last ? ST_IDLE : ST_READ;
      end
      ST_BAD: begin
        if (out_free) begin
          cmd_o.show_bad = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.show || cmd_o.show_bad) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/radix_digit_emitter.sv]
// Top level of the radix digit emitter: joins the controller and the datapath
// to the input and output channels. Depends on rde_pkg, rde_if, rde_ctrl, rde_datapath.
//
//   Channel  Direction  Payload                                  Handshake
//   in_i     sink       number[63:0], radix[5:0]                 valid / ready
//   out_o    source     digit_char[6:0], last_digit, bad_radix   valid / ready
//
// For an item with a valid radix, the restoring divider retires eight quotient bits
// per cycle and divides the 64-bit value repeatedly, storing one digit per
// division; each digit is then read from the registered digit store and loaded into
// the output register. Worst case is radix 2 with all bits set: 64 digits.
// An invalid radix gives its single result once the output register is free.
// Reset clears the state machine, the output valid flag and the digit count; the
// digit store needs no clearing because every entry is written before it is read.
// A stalled output holds its item; the block accepts the next item as soon as the
// last result of the previous one sits in the output register.

module radix_digit_emitter (
  input  logic         clk_i,
  input  logic         rst_ni,
  rde_in_if.sink       in_i,
  rde_out_if.source    out_o
);

  rde_pkg::rde_cmd_t    cmd_s;
  rde_pkg::rde_status_t status_s;
  logic                 in_ready_s;
  logic                 out_valid_s;

  // The controller alone decides the handshake; it sees the datapath only through
  // the command and status structs.
  rde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready_s),
    .out_valid_o (out_valid_s),
    .out_ready_i (out_o.ready),
    .status_i    (status_s),
    .cmd_o       (cmd_s)
  );

  rde_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .number_i     (in_i.number),
    .radix_i      (in_i.radix),
    .cmd_i        (cmd_s),
    .status_o     (status_s),
    .digit_char_o (out_o.digit_char),
    .last_digit_o (out_o.last_digit),
    .bad_radix_o  (out_o.bad_radix)
  );

  assign in_i.ready  = in_ready_s;
  assign out_o.valid = out_valid_s;

`ifndef SYNTHESIS
  // After an item is taken the block is not ready in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted in two consecutive cycles");

  // A store read is always followed by loading the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_s.fetch |=> cmd_s.show)
    else $error("digit fetch not followed by output load");

  // A store read or the invalid-radix load is only issued when the output register is empty or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_s.fetch || cmd_s.show_bad) |-> (!out_o.valid || out_o.ready))
    else $error("output register overwritten while holding an item");

  // The invalid-radix result is a lone final item with a zero character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_radix) |-> (out_o.last_digit && (out_o.digit_char == '0)))
    else $error("malformed invalid-radix result");
`endif

endmodule
